// File: design/rkr_pkg.sv
// shared types and constants of the ring key range block
// request and result payloads, action codes, width of the classified record
// no dependencies
package rkr_pkg;

    localparam int FIELD_BITS      = 64;
    localparam int KEY_BITS_DEF    = 64;
    localparam int QUEUE_DEPTH_DEF = 2;

    // number of key-wide words in the record handed from front to back
    localparam int CLS_KEYS = 20;

    typedef enum logic [2:0] {
        ACT_SIZE      = 3'd0,
        ACT_KEY_IN    = 3'd1,
        ACT_INVERT    = 3'd2,
        ACT_INSIDE    = 3'd3,
        ACT_OVERLAP   = 3'd4,
        ACT_UNION     = 3'd5,
        ACT_MINUS     = 3'd6,
        ACT_INTERSECT = 3'd7
    } action_t;

    typedef struct packed {
        action_t               action;
        logic [FIELD_BITS-1:0] a_min;
        logic [FIELD_BITS-1:0] a_max;
        logic [FIELD_BITS-1:0] b_min;
        logic [FIELD_BITS-1:0] b_max;
        logic [FIELD_BITS-1:0] probe_key;
    } req_t;

    typedef struct packed {
        logic                  flag;
        logic [1:0]            range_count;
        logic [FIELD_BITS-1:0] first_min;
        logic [FIELD_BITS-1:0] first_max;
        logic [FIELD_BITS-1:0] second_min;
        logic [FIELD_BITS-1:0] second_max;
        logic [FIELD_BITS-1:0] key_count;
    } res_t;

    // bits of the classified record: action code plus the key-wide words
    function automatic int cls_bits(input int key_bits);
        return $bits(action_t) + CLS_KEYS * key_bits;
    endfunction

endpackage

// File: design/rkr_front.sv
// front end: masks the request keys and forms every ring distance the ops need
// depends on rkr_pkg; feeds rkr_queue with a flat classified record
module rkr_front #(
    parameter int KEY_BITS = rkr_pkg::KEY_BITS_DEF
) (
    input  rkr_pkg::req_t                           req,
    output logic [rkr_pkg::cls_bits(KEY_BITS)-1:0]  cls
);
    import rkr_pkg::*;

    typedef logic [KEY_BITS-1:0] key_t;

    // record layout, mirrored in rkr_back
    typedef struct packed {
        action_t action;
        key_t    a_lo;
        key_t    a_hi;
        key_t    b_lo;
        key_t    b_hi;
        key_t    a_hi_inc;
        key_t    a_lo_dec;
        key_t    b_hi_inc;
        key_t    b_lo_dec;
        key_t    key_count;
        key_t    da;        // a_hi - a_lo
        key_t    dka;       // probe - a_lo
        key_t    dbl;       // b_lo - a_lo
        key_t    dbh;       // b_hi - a_lo
        key_t    dbhp;      // b_hi + 1 - a_lo
        key_t    dblm;      // b_lo - 1 - a_lo
        key_t    db;        // b_hi - b_lo
        key_t    dal_b;     // a_lo - b_lo
        key_t    dah_b;     // a_hi - b_lo
        key_t    dah_ib;    // a_hi - (b_hi + 1)
        key_t    dal_ib;    // a_lo - (b_hi + 1)
    } cls_t;

    key_t a_lo;
    key_t a_hi;
    key_t b_lo;
    key_t b_hi;
    key_t probe;
    cls_t c;

    // keep only the low key bits of each field
    assign a_lo  = req.a_min[KEY_BITS-1:0];
    assign a_hi  = req.a_max[KEY_BITS-1:0];
    assign b_lo  = req.b_min[KEY_BITS-1:0];
    assign b_hi  = req.b_max[KEY_BITS-1:0];
    assign probe = req.probe_key[KEY_BITS-1:0];

    // neighbors of the bounds and distances from each base
    always_comb
    begin
        c.action    = req.action;
        c.a_lo      = a_lo;
        c.a_hi      = a_hi;
        c.b_lo      = b_lo;
        c.b_hi      = b_hi;
        c.a_hi_inc  = a_hi + key_t'(1);
        c.a_lo_dec  = a_lo - key_t'(1);
        c.b_hi_inc  = b_hi + key_t'(1);
        c.b_lo_dec  = b_lo - key_t'(1);
        c.key_count = a_hi - a_lo + key_t'(1);
        c.da        = a_hi - a_lo;
        c.dka       = probe - a_lo;
        c.dbl       = b_lo - a_lo;
        c.dbh       = b_hi - a_lo;
        c.dbhp      = b_hi - a_lo + key_t'(1);
        c.dblm      = b_lo + ~a_lo;
        c.db        = b_hi - b_lo;
        c.dal_b     = a_lo - b_lo;
        c.dah_b     = a_hi - b_lo;
        c.dah_ib    = a_hi + ~b_hi;
        c.dal_ib    = a_lo + ~b_hi;
    end

    assign cls = c;

endmodule

// File: design/rkr_queue.sv
// short fifo between front and back, push and pop in the same cycle
// no package dependency; generic payload width
module rkr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_stall,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_stall,
    output logic [WIDTH-1:0] pop_data
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             push;
    logic             pop;

    // handshake on both sides
    assign push_stall = (count_reg == CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && !push_stall;
    assign pop        = pop_valid && !pop_stall;
    assign pop_data   = mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: design/rkr_back.sv
// back end: compares the distances, picks the result ranges, holds the result
// depends on rkr_pkg; takes the classified record from rkr_queue
module rkr_back #(
    parameter int KEY_BITS = rkr_pkg::KEY_BITS_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cls_valid,
    output logic                                    cls_stall,
    input  logic [rkr_pkg::cls_bits(KEY_BITS)-1:0]  cls,
    output logic                                    res_valid,
    input  logic                                    res_stall,
    output rkr_pkg::res_t                           res
);
    import rkr_pkg::*;

    typedef logic [KEY_BITS-1:0] key_t;

    // record layout, mirrored in rkr_front
    typedef struct packed {
        action_t action;
        key_t    a_lo;
        key_t    a_hi;
        key_t    b_lo;
        key_t    b_hi;
        key_t    a_hi_inc;
        key_t    a_lo_dec;
        key_t    b_hi_inc;
        key_t    b_lo_dec;
        key_t    key_count;
        key_t    da;
        key_t    dka;
        key_t    dbl;
        key_t    dbh;
        key_t    dbhp;
        key_t    dblm;
        key_t    db;
        key_t    dal_b;
        key_t    dah_b;
        key_t    dah_ib;
        key_t    dal_ib;
    } cls_t;

    cls_t       c;
    logic       full_a;
    logic       full_b;
    logic       key_in_a;
    logic       b_in_a;
    logic       a_in_inv_b;
    logic       ring_cover;
    logic       b_after_a;
    logic       a_after_b;
    key_t       dl;
    key_t       dh;
    key_t       after_b;
    key_t       before_b;
    logic [1:0] d_cnt;
    key_t       d_r1_lo;
    key_t       d_r1_hi;
    key_t       d_r2_lo;
    key_t       d_r2_hi;
    logic       flag;
    logic [1:0] cnt;
    key_t       r1_lo;
    key_t       r1_hi;
    key_t       r2_lo;
    key_t       r2_hi;
    res_t       res_next;
    res_t       res_reg;
    logic       res_valid_reg;

    assign c = cls_t'(cls);

    // range shape and position tests
    assign full_a   = (c.da == '1);
    assign full_b   = (c.db == '1);
    assign key_in_a = (c.dka <= c.da);
    assign b_in_a   = full_a || !((c.dbh < c.dbl) || (c.da < c.dbl) || (c.da < c.dbh));
    // a inside the complement of b, meaningful when b is not full
    assign a_in_inv_b = !((c.dah_ib < c.dal_ib) || (~c.db <= c.dal_ib)
                          || (~c.db <= c.dah_ib));
    // complement of b inside a, so a and b cover the ring; meaningful when neither is full
    assign ring_cover = !((c.dblm < c.dbhp) || (c.da < c.dbhp) || (c.da < c.dblm));
    assign b_after_a = (c.dbl > c.da);
    assign a_after_b = (c.dal_b > c.db);

    // difference operands: b itself, or the complement of b for intersect
    always_comb
    begin
        if (c.action == ACT_INTERSECT)
        begin
            dl       = c.dbhp;
            dh       = c.dblm;
            after_b  = c.b_lo;
            before_b = c.b_hi;
        end
        else
        begin
            dl       = c.dbl;
            dh       = c.dbh;
            after_b  = c.b_hi_inc;
            before_b = c.b_lo_dec;
        end
    end

    // a minus the chosen range
    always_comb
    begin
        d_cnt   = 2'd0;
        d_r1_lo = '0;
        d_r1_hi = '0;
        d_r2_lo = '0;
        d_r2_hi = '0;
        if (dh < dl)
        begin
            // subtracted range wraps past the start of a
            if (c.da > dh)
            begin
                d_cnt   = 2'd1;
                d_r1_lo = after_b;
                d_r1_hi = (c.da < dl) ? c.a_hi : before_b;
            end
        end
        else if (c.da < dl)
        begin
            d_cnt   = 2'd1;
            d_r1_lo = c.a_lo;
            d_r1_hi = c.a_hi;
        end
        else if (dl == '0)
        begin
            // both ranges start together
            if (c.da > dh)
            begin
                d_cnt   = 2'd1;
                d_r1_lo = after_b;
                d_r1_hi = c.a_hi;
            end
        end
        else
        begin
            d_cnt   = 2'd1;
            d_r1_lo = c.a_lo;
            d_r1_hi = before_b;
            if (c.da > dh)
            begin
                d_cnt   = 2'd2;
                d_r2_lo = after_b;
                d_r2_hi = c.a_hi;
            end
        end
    end

    // result selection per action
    always_comb
    begin
        flag  = 1'b0;
        cnt   = 2'd0;
        r1_lo = '0;
        r1_hi = '0;
        r2_lo = '0;
        r2_hi = '0;
        case (c.action)
            ACT_KEY_IN:
            begin
                flag = key_in_a;
            end
            ACT_INVERT:
            begin
                if (!full_a)
                begin
                    flag  = 1'b1;
                    cnt   = 2'd1;
                    r1_lo = c.a_hi_inc;
                    r1_hi = c.a_lo_dec;
                end
            end
            ACT_INSIDE:
            begin
                flag = b_in_a;
            end
            ACT_OVERLAP:
            begin
                flag = full_b || !a_in_inv_b;
            end
            ACT_UNION:
            begin
                cnt = 2'd1;
                if (full_a)
                begin
                    r1_lo = c.a_lo;
                    r1_hi = c.a_hi;
                end
                else if (full_b)
                begin
                    r1_lo = c.b_lo;
                    r1_hi = c.b_hi;
                end
                else if (!b_after_a)
                begin
                    // b starts inside a
                    if (ring_cover)
                    begin
                        r1_lo = '0;
                        r1_hi = '1;
                    end
                    else if (c.da < c.dbh)
                    begin
                        r1_lo = c.a_lo;
                        r1_hi = c.b_hi;
                    end
                    else
                    begin
                        r1_lo = c.a_lo;
                        r1_hi = c.a_hi;
                    end
                end
                else if (a_after_b)
                begin
                    // disjoint ranges come back as they are
                    cnt   = 2'd2;
                    r1_lo = c.a_lo;
                    r1_hi = c.a_hi;
                    r2_lo = c.b_lo;
                    r2_hi = c.b_hi;
                end
                else
                begin
                    // a starts inside b
                    if (ring_cover)
                    begin
                        r1_lo = '0;
                        r1_hi = '1;
                    end
                    else if (c.db < c.dah_b)
                    begin
                        r1_lo = c.b_lo;
                        r1_hi = c.a_hi;
                    end
                    else
                    begin
                        r1_lo = c.b_lo;
                        r1_hi = c.b_hi;
                    end
                end
            end
            ACT_MINUS:
            begin
                if (!full_b)
                begin
                    cnt   = d_cnt;
                    r1_lo = d_r1_lo;
                    r1_hi = d_r1_hi;
                    r2_lo = d_r2_lo;
                    r2_hi = d_r2_hi;
                end
            end
            ACT_INTERSECT:
            begin
                if (full_b)
                begin
                    cnt   = 2'd1;
                    r1_lo = c.a_lo;
                    r1_hi = c.a_hi;
                end
                else
                begin
                    cnt   = d_cnt;
                    r1_lo = d_r1_lo;
                    r1_hi = d_r1_hi;
                    r2_lo = d_r2_lo;
                    r2_hi = d_r2_hi;
                end
            end
            default:
            begin
                flag = 1'b0;
            end
        endcase
    end

    // widen to the result fields
    always_comb
    begin
        res_next.flag        = flag;
        res_next.range_count = cnt;
        res_next.first_min   = FIELD_BITS'(r1_lo);
        res_next.first_max   = FIELD_BITS'(r1_hi);
        res_next.second_min  = FIELD_BITS'(r2_lo);
        res_next.second_max  = FIELD_BITS'(r2_hi);
        res_next.key_count   = FIELD_BITS'(c.key_count);
    end

    // output register, refilled whenever it is empty or being taken
    assign cls_stall = res_valid_reg && res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (!cls_stall)
        begin
            res_valid_reg <= cls_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cls_valid && !cls_stall)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

// File: design/ring_key_range_ops_top.sv
// top level of the ring key range block
// depends on rkr_pkg, rkr_front, rkr_queue and rkr_back
//
// Set operations on inclusive key ranges on a ring of 2^KEY_BITS keys: size,
// membership of probe_key, inversion, containment, overlap, union, difference
// and intersection, selected by the action field. Every request gives exactly
// one result, in order. A new request is taken every cycle while req_stall is
// low; an accepted request is stored in the queue and its result then loaded
// into the output register. The front end forms all ring distances as the
// request enters, a queue of QUEUE_DEPTH entries holds the classified requests,
// and the back end compares them and loads the output register, so a stall on
// the result side reaches req_stall only once the queue has filled. Key bits
// above KEY_BITS are ignored on input and returned as zero.
module ring_key_range_ops_top #(
    parameter int KEY_BITS    = rkr_pkg::KEY_BITS_DEF,
    parameter int QUEUE_DEPTH = rkr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  rkr_pkg::req_t req,
    output logic          res_valid,
    input  logic          res_stall,
    output rkr_pkg::res_t res
);
    import rkr_pkg::*;

    localparam int CLS_W = cls_bits(KEY_BITS);

    logic [CLS_W-1:0] front_cls;
    logic [CLS_W-1:0] queue_cls;
    logic             queue_valid;
    logic             back_stall;

    // classify the incoming request
    rkr_front #(
        .KEY_BITS (KEY_BITS)
    ) u_front (
        .req (req),
        .cls (front_cls)
    );

    // decouple front and back
    rkr_queue #(
        .WIDTH (CLS_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (req_valid),
        .push_stall (req_stall),
        .push_data  (front_cls),
        .pop_valid  (queue_valid),
        .pop_stall  (back_stall),
        .pop_data   (queue_cls)
    );

    // carry out the operation and hold the result
    rkr_back #(
        .KEY_BITS (KEY_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls_valid (queue_valid),
        .cls_stall (back_stall),
        .cls       (queue_cls),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

endmodule

// File: tb/rkr_range_model_pkg.sv
// predictor and scoreboard for the ring key range block
// computes the expected result of each request and checks results in order
// depends on rkr_pkg
package rkr_range_model_pkg;

    import rkr_pkg::*;

    typedef logic [FIELD_BITS-1:0] key_t;

    localparam int   KB    = KEY_BITS_DEF;
    localparam key_t KMASK = {FIELD_BITS{1'b1}} >> (FIELD_BITS - KB);

    // inclusive range on the ring, running upward from lo to hi
    typedef struct packed {
        key_t lo;
        key_t hi;
    } arc_t;

    // modular distance of x above base
    function automatic key_t rdist(key_t x, key_t base);
        return (x - base) & KMASK;
    endfunction

    function automatic arc_t arc(key_t lo, key_t hi);
        arc_t r;
        r.lo = lo & KMASK;
        r.hi = hi & KMASK;
        return r;
    endfunction

    function automatic bit arc_full(arc_t r);
        return ((r.hi + key_t'(1)) & KMASK) == r.lo;
    endfunction

    function automatic arc_t arc_flip(arc_t r);
        return arc(r.hi + key_t'(1), r.lo - key_t'(1));
    endfunction

    // inner lies entirely inside outer
    function automatic bit arc_covers(arc_t outer, arc_t inner);
        key_t w;
        w = rdist(outer.hi, outer.lo);
        if (arc_full(outer))
            return 1'b1;
        if (rdist(inner.hi, outer.lo) < rdist(inner.lo, outer.lo))
            return 1'b0;
        if (w < rdist(inner.lo, outer.lo))
            return 1'b0;
        if (w < rdist(inner.hi, outer.lo))
            return 1'b0;
        return 1'b1;
    endfunction

    // keys of a that are not in b, as up to two ranges
    function automatic int arc_minus(arc_t a, arc_t b, output arc_t o1, output arc_t o2);
        key_t da;
        key_t dbl;
        key_t dbh;
        da  = rdist(a.hi, a.lo);
        dbl = rdist(b.lo, a.lo);
        dbh = rdist(b.hi, a.lo);
        o1  = '0;
        o2  = '0;
        if (arc_full(b))
            return 0;
        // b wraps past the start of a
        if (dbh < dbl)
        begin
            if (da <= dbh)
                return 0;
            if (da < dbl)
                o1 = arc(b.hi + key_t'(1), a.hi);
            else
                o1 = arc(b.hi + key_t'(1), b.lo - key_t'(1));
            return 1;
        end
        if (da < dbl)
        begin
            o1 = a;
            return 1;
        end
        // shared minimum: what is left starts right after b
        if (dbl == '0)
        begin
            if (da <= dbh)
                return 0;
            o1 = arc(b.hi + key_t'(1), a.hi);
            return 1;
        end
        o1 = arc(a.lo, b.lo - key_t'(1));
        if (da <= dbh)
            return 1;
        o2 = arc(b.hi + key_t'(1), a.hi);
        return 2;
    endfunction

    function automatic res_t predict_result(req_t q);
        arc_t a;
        arc_t b;
        arc_t s;
        arc_t t;
        arc_t r1;
        arc_t r2;
        key_t k;
        int   cnt;
        bit   flag;
        res_t r;
        a    = arc(q.a_min, q.a_max);
        b    = arc(q.b_min, q.b_max);
        k    = q.probe_key & KMASK;
        r1   = '0;
        r2   = '0;
        cnt  = 0;
        flag = 1'b0;
        case (q.action)
            ACT_KEY_IN:
                flag = rdist(k, a.lo) <= rdist(a.hi, a.lo);
            ACT_INVERT:
                if (!arc_full(a))
                begin
                    r1   = arc_flip(a);
                    cnt  = 1;
                    flag = 1'b1;
                end
            ACT_INSIDE:
                flag = arc_covers(a, b);
            ACT_OVERLAP:
                flag = arc_full(b) || !arc_covers(arc_flip(b), a);
            ACT_UNION:
            begin
                if (arc_full(a))
                begin
                    r1  = a;
                    cnt = 1;
                end
                else if (arc_full(b))
                begin
                    r1  = b;
                    cnt = 1;
                end
                else
                begin
                    // s is the range whose span holds the start of t
                    s   = a;
                    t   = b;
                    cnt = 1;
                    if (rdist(t.lo, s.lo) > rdist(s.hi, s.lo))
                    begin
                        s = b;
                        t = a;
                        if (rdist(t.lo, s.lo) > rdist(s.hi, s.lo))
                        begin
                            r1  = a;
                            r2  = b;
                            cnt = 2;
                        end
                    end
                    if (cnt == 1)
                    begin
                        if (arc_covers(t, arc_flip(s)))
                            r1 = arc('0, KMASK);
                        else if (rdist(s.hi, s.lo) < rdist(t.hi, s.lo))
                            r1 = arc(s.lo, t.hi);
                        else
                            r1 = s;
                    end
                end
            end
            ACT_MINUS:
                cnt = arc_minus(a, b, r1, r2);
            ACT_INTERSECT:
                if (arc_full(b))
                begin
                    r1  = a;
                    cnt = 1;
                end
                else
                    cnt = arc_minus(a, arc_flip(b), r1, r2);
            default:
                ;
        endcase
        if (cnt < 2)
            r2 = '0;
        if (cnt < 1)
            r1 = '0;
        r.flag        = flag;
        r.range_count = cnt[1:0];
        r.first_min   = r1.lo;
        r.first_max   = r1.hi;
        r.second_min  = r2.lo;
        r.second_max  = r2.hi;
        r.key_count   = (a.hi - a.lo + key_t'(1)) & KMASK;
        return r;
    endfunction

    // expected results in request order, compared against what comes out
    class range_scoreboard;
        res_t pending_q[$];
        int   errors;

        function new();
            errors = 0;
        endfunction

        function void note_request(req_t q);
            pending_q.push_back(predict_result(q));
        endfunction

        function int outstanding();
            return pending_q.size();
        endfunction

        function void compare_field(string name, key_t want, key_t got);
            if (want !== got)
            begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (pending_q.size() == 0)
            begin
                $display("%0t: result with no request pending, expected none, actual %h",
                         $time, got);
                errors++;
                return;
            end
            want = pending_q.pop_front();
            compare_field("flag", key_t'(want.flag), key_t'(got.flag));
            compare_field("range_count", key_t'(want.range_count), key_t'(got.range_count));
            compare_field("first_min", want.first_min, got.first_min);
            compare_field("first_max", want.first_max, got.first_max);
            compare_field("second_min", want.second_min, got.second_min);
            compare_field("second_max", want.second_max, got.second_max);
            compare_field("key_count", want.key_count, got.key_count);
        endfunction
    endclass

endpackage

// File: tb/ring_key_range_ops_top_test.sv
// testbench top for ring_key_range_ops_top
// directed and random range requests, bursty sender, stalling receiver
// depends on rkr_pkg, rkr_range_model_pkg and the block itself
module ring_key_range_ops_top_test;

    import rkr_pkg::*;
    import rkr_range_model_pkg::*;

    localparam int RANDOM_ITEMS = 1525;
    localparam int PRESSURE_ITEMS = 40;
    localparam int HOLD_CYCLES = 80;
    localparam int IDLE_LIMIT = 2000;
    localparam int TAIL_CYCLES = 10;

    localparam key_t ONES = '1;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic res_valid;
    logic res_stall;
    res_t res;

    range_scoreboard sb = new();

    bit hold_req;
    int idle_cycles;

    ring_key_range_ops_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // offer one request and wait until it is taken
    task automatic send_request(input req_t q);
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= q;
        do
            @(posedge clk);
        while (req_stall);
        sb.note_request(q);
    endtask

    task automatic send_fields(input action_t act, input key_t a0, input key_t a1,
                               input key_t b0, input key_t b1, input key_t probe);
        req_t q;
        q.action    = act;
        q.a_min     = a0;
        q.a_max     = a1;
        q.b_min     = b0;
        q.b_max     = b1;
        q.probe_key = probe;
        send_request(q);
    endtask

    task automatic drop_valid();
        @(negedge clk);
        req_valid <= 1'b0;
    endtask

    // keys biased toward the ends of the ring and single bits
    function automatic key_t rand_key();
        case ($urandom_range(4))
            0, 1:    return {$urandom, $urandom};
            2:       return key_t'($urandom_range(15));
            3:       return ~key_t'($urandom_range(15));
            default: return key_t'(1) << $urandom_range(63);
        endcase
    endfunction

    // distance from min to max; all ones gives the full ring
    function automatic key_t rand_len();
        case ($urandom_range(5))
            0:       return key_t'($urandom_range(7));
            1:       return key_t'($urandom_range(5000));
            2:       return {$urandom, $urandom};
            3:       return ONES;
            4:       return ~key_t'($urandom_range(7));
            default: return {$urandom, $urandom} >> $urandom_range(1, 40);
        endcase
    endfunction

    function automatic key_t jitter();
        return key_t'($urandom_range(6)) - key_t'(3);
    endfunction

    // b and the probe are mostly placed near the ends of a so ranges interact
    function automatic req_t random_request();
        req_t q;
        q.action = action_t'($urandom_range(7));
        q.a_min  = rand_key();
        q.a_max  = q.a_min + rand_len();
        case ($urandom_range(3))
            0:       q.b_min = rand_key();
            1:       q.b_min = q.a_min + jitter();
            2:       q.b_min = q.a_max + jitter();
            default: q.b_min = q.a_min + ((q.a_max - q.a_min) >> $urandom_range(1, 8));
        endcase
        case ($urandom_range(2))
            0:       q.b_max = q.b_min + rand_len();
            1:       q.b_max = q.a_max + jitter();
            default: q.b_max = q.a_min + jitter();
        endcase
        case ($urandom_range(2))
            0:       q.probe_key = rand_key();
            1:       q.probe_key = q.a_min + jitter();
            default: q.probe_key = q.a_max + jitter();
        endcase
        return q;
    endfunction

    // receiver: stall rate changes from phase to phase, long hold on request
    initial
    begin
        int stall_pct;
        int phase_left;
        int hold_left;
        stall_pct  = 0;
        phase_left = 0;
        hold_left  = 0;
        res_stall  = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                res_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    case ($urandom_range(3))
                        0:       stall_pct = 0;
                        1:       stall_pct = 20;
                        2:       stall_pct = 50;
                        default: stall_pct = 90;
                    endcase
                    phase_left = $urandom_range(20, 200);
                end
                phase_left--;
                res_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            sb.check_result(res);
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (res_valid && !res_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // main stimulus
    initial
    begin
        int n_sent;
        int burst;
        int gap;
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        hold_req    = 1'b0;
        idle_cycles = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: sizes of single key, full ring and wrapped range
        send_fields(ACT_SIZE, '0, '0, '0, '0, '0);
        send_fields(ACT_SIZE, '0, ONES, ONES, ONES, ONES);
        send_fields(ACT_SIZE, ONES, '0, '0, ONES, '0);
        // membership in a wrapped range and at the top key
        send_fields(ACT_KEY_IN, ONES - 3, 64'd2, '0, '0, 64'd1);
        send_fields(ACT_KEY_IN, ONES - 3, 64'd2, '0, '0, 64'd5);
        send_fields(ACT_KEY_IN, '0, ONES, '0, '0, ONES);
        // inversion of full ring, top key and plain range
        send_fields(ACT_INVERT, 64'd5, 64'd4, '0, '0, '0);
        send_fields(ACT_INVERT, ONES, ONES, '0, '0, '0);
        send_fields(ACT_INVERT, 64'd10, 64'd20, '0, '0, '0);
        // containment
        send_fields(ACT_INSIDE, 64'd10, 64'd100, 64'd20, 64'd30, '0);
        send_fields(ACT_INSIDE, 64'd10, 64'd100, 64'd90, 64'd5, '0);
        send_fields(ACT_INSIDE, 64'd7, 64'd6, ONES, 64'd3, '0);
        // overlap sharing one key, complement, full b
        send_fields(ACT_OVERLAP, 64'd10, 64'd20, 64'd20, 64'd30, '0);
        send_fields(ACT_OVERLAP, 64'd10, 64'd20, 64'd21, 64'd9, '0);
        send_fields(ACT_OVERLAP, 64'd10, 64'd20, 64'd40, 64'd39, '0);
        // union: touching pair stays two ranges, ring cover, merge, full a
        send_fields(ACT_UNION, 64'd10, 64'd20, 64'd21, 64'd30, '0);
        send_fields(ACT_UNION, 64'd10, 64'd20, 64'd15, 64'd12, '0);
        send_fields(ACT_UNION, 64'd10, 64'd20, 64'd15, 64'd40, '0);
        send_fields(ACT_UNION, '0, ONES, 64'd15, 64'd40, '0);
        // difference: nothing left, shared minimum, middle cut, full b, extremes
        send_fields(ACT_MINUS, 64'd10, 64'd20, 64'd5, 64'd25, '0);
        send_fields(ACT_MINUS, 64'd10, 64'd20, 64'd10, 64'd15, '0);
        send_fields(ACT_MINUS, 64'd10, 64'd50, 64'd20, 64'd30, '0);
        send_fields(ACT_MINUS, 64'd10, 64'd50, 64'd8, 64'd7, '0);
        send_fields(ACT_MINUS, ONES, ONES, '0, '0, ONES);
        // intersection with full b and with two wrapped ranges
        send_fields(ACT_INTERSECT, ONES - 5, 64'd5, 64'd7, 64'd6, '0);
        send_fields(ACT_INTERSECT, ONES - 5, 64'd5, ONES - 2, 64'd10, '0);

        // long receiver hold while requests keep coming, so the queue fills
        hold_req = 1'b1;
        repeat (PRESSURE_ITEMS)
            send_request(random_request());
        drop_valid();

        // random bursts with random gaps, one full drain halfway
        n_sent = 0;
        while (n_sent < RANDOM_ITEMS)
        begin
            burst = $urandom_range(1, 40);
            gap   = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
            for (int i = 0; i < burst && n_sent < RANDOM_ITEMS; i++)
            begin
                send_request(random_request());
                n_sent++;
                if (n_sent == RANDOM_ITEMS / 2)
                begin
                    drop_valid();
                    while (sb.outstanding() != 0)
                        @(negedge clk);
                end
            end
            repeat (gap)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
            end
        end
        drop_valid();

        // drain and let the pipeline settle
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
